// ===== rtl/acx_pkg.sv =====
// Package for the add-with-carry executor: sizes, opcodes, addressing modes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package acx_pkg;

  localparam int ADDR_BITS    = 16;
  localparam int MEM_DEPTH    = 1 << ADDR_BITS;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_Y = CFG_IDX_BITS'(1);

  localparam logic [7:0] OP_ADC_IMM  = 8'h69;
  localparam logic [7:0] OP_ADC_ZP   = 8'h65;
  localparam logic [7:0] OP_ADC_ZPX  = 8'h75;
  localparam logic [7:0] OP_ADC_ABS  = 8'h6D;
  localparam logic [7:0] OP_ADC_ABSX = 8'h7D;
  localparam logic [7:0] OP_ADC_ABSY = 8'h79;
  localparam logic [7:0] OP_ADC_INDX = 8'h61;
  localparam logic [7:0] OP_ADC_INDY = 8'h71;

  localparam logic [2:0] CYC_NONE = 3'd0;
  localparam logic [2:0] CYC_IMM  = 3'd2;
  localparam logic [2:0] CYC_ZP   = 3'd3;
  localparam logic [2:0] CYC_MID  = 3'd4;
  localparam logic [2:0] CYC_IND  = 3'd6;

  typedef enum logic [3:0] {
    AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY, AM_BAD
  } addr_mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_B1, S_B2, S_PTR_LO, S_PTR_HI, S_PTR_W, S_RD_EA, S_ADD, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    AS_PC1, AS_PC2, AS_ZP, AS_ZP1, AS_EA
  } addr_sel_t;

  typedef struct packed {
    logic      accept;
    logic      cap_b1;
    logic      cap_b2;
    logic      cap_ptr_lo;
    logic      do_add;
    logic      load_out;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    addr_mode_t am;
  } status_t;

  function automatic addr_mode_t decode_am(input logic [7:0] op);
    addr_mode_t am;
    case (op)
      OP_ADC_IMM:  am = AM_IMM;
      OP_ADC_ZP:   am = AM_ZP;
      OP_ADC_ZPX:  am = AM_ZPX;
      OP_ADC_ABS:  am = AM_ABS;
      OP_ADC_ABSX: am = AM_ABSX;
      OP_ADC_ABSY: am = AM_ABSY;
      OP_ADC_INDX: am = AM_INDX;
      OP_ADC_INDY: am = AM_INDY;
      default:     am = AM_BAD;
    endcase
    return am;
  endfunction

  function automatic logic [2:0] am_cycles(input addr_mode_t am);
    logic [2:0] c;
    case (am)
      AM_IMM:  c = CYC_IMM;
      AM_ZP:   c = CYC_ZP;
      AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY: c = CYC_MID;
      AM_INDX, AM_INDY: c = CYC_IND;
      default: c = CYC_NONE;
    endcase
    return c;
  endfunction

  // instruction length in bytes
  function automatic logic [1:0] am_len(input addr_mode_t am);
    logic [1:0] l;
    case (am)
      AM_ABS, AM_ABSX, AM_ABSY: l = 2'd3;
      default: l = 2'd2;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/acx_in_if.sv =====
// Input channel: one word is a memory write or an execute request.
// Depends on nothing.
interface acx_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;
  logic [7:0]  opcode;

  modport source (output valid, mode, mem_addr, mem_data, opcode, input ready);
  modport sink   (input valid, mode, mem_addr, mem_data, opcode, output ready);
endinterface

// ===== rtl/acx_out_if.sv =====
// Result channel: accumulator, flags, program counter and timing of one item.
// Depends on nothing.
interface acx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic        carry_flag;
  logic        zero_flag;
  logic        overflow_flag;
  logic        negative_flag;
  logic [15:0] pc_out;
  logic [2:0]  cycle_count;
  logic        bad_opcode;

  modport source (output valid, acc_out, carry_flag, zero_flag, overflow_flag,
                  negative_flag, pc_out, cycle_count, bad_opcode, input ready);
  modport sink   (input valid, acc_out, carry_flag, zero_flag, overflow_flag,
                  negative_flag, pc_out, cycle_count, bad_opcode, output ready);
endinterface

// ===== rtl/acx_cfg_if.sv =====
// Configuration write channel: register index and data.
// Uses acx_pkg for the index width.
interface acx_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [acx_pkg::CFG_IDX_BITS-1:0] index;
  logic [7:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cpu_add_with_carry_executor_core.sv =====
// Add-with-carry executor, top level: one request channel, one result channel and a
// configuration write channel for the X and Y index registers. A request word either
// stores one byte in the 2^ADDR_BITS byte memory (mode 0) or executes one of the eight
// binary ADC opcodes at the current program counter (mode 1); each word yields one
// result word with accumulator, C/Z/V/N, program counter, nominal cycle count and a
// bad-opcode bit. Words are handled one at a time; the next word is taken once the
// current one is in the result register, which may still be waiting on the sink.
// Pacing is set by the single memory port with registered read data: every operand,
// pointer and effective-address byte is one sequential read. Memory contents are
// undefined after reset and need no clearing.
// Depends on acx_pkg, acx_in_if, acx_out_if, acx_cfg_if, acx_ctrl, acx_datapath.
module cpu_add_with_carry_executor_core (
  input  logic       clk,
  input  logic       rst,
  acx_in_if.sink     req,
  acx_out_if.source  rsp,
  acx_cfg_if.sink    cfg
);

  acx_pkg::cmd_t    cmd;
  acx_pkg::status_t status;

  acx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  acx_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_mode       (req.mode),
    .in_mem_addr   (req.mem_addr),
    .in_mem_data   (req.mem_data),
    .in_opcode     (req.opcode),
    .cfg           (cfg),
    .acc_out       (rsp.acc_out),
    .carry_flag    (rsp.carry_flag),
    .zero_flag     (rsp.zero_flag),
    .overflow_flag (rsp.overflow_flag),
    .negative_flag (rsp.negative_flag),
    .pc_out        (rsp.pc_out),
    .cycle_count   (rsp.cycle_count),
    .bad_opcode    (rsp.bad_opcode)
  );

endmodule

// ===== rtl/acx_ctrl.sv =====
// Controller state machine: sequences operand fetches, the add and result hand-off.
// Uses acx_pkg types; drives the datapath through cmd_t.
module acx_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  acx_pkg::status_t status,
  output acx_pkg::cmd_t    cmd
);

  acx_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acx_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      acx_pkg::S_IDLE: begin
        if (in_valid) state_next = in_mode ? acx_pkg::S_B1 : acx_pkg::S_DONE;
      end
      acx_pkg::S_B1: state_next = acx_pkg::S_B2;
      acx_pkg::S_B2: begin
        unique case (status.am) inside
          acx_pkg::AM_BAD:                   state_next = acx_pkg::S_DONE;
          acx_pkg::AM_IMM:                   state_next = acx_pkg::S_ADD;
          acx_pkg::AM_INDX, acx_pkg::AM_INDY: state_next = acx_pkg::S_PTR_LO;
          default:                           state_next = acx_pkg::S_RD_EA;
        endcase
      end
      acx_pkg::S_PTR_LO: state_next = acx_pkg::S_PTR_HI;
      acx_pkg::S_PTR_HI: state_next = acx_pkg::S_PTR_W;
      acx_pkg::S_PTR_W:  state_next = acx_pkg::S_RD_EA;
      acx_pkg::S_RD_EA:  state_next = acx_pkg::S_ADD;
      acx_pkg::S_ADD:    state_next = acx_pkg::S_DONE;
      acx_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = acx_pkg::S_IDLE;
      end
      default: state_next = acx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.cap_b1     = 1'b0;
    cmd.cap_b2     = 1'b0;
    cmd.cap_ptr_lo = 1'b0;
    cmd.do_add     = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.addr_sel   = acx_pkg::AS_PC1;
    unique case (state)
      acx_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      acx_pkg::S_B1: begin
        cmd.cap_b1   = 1'b1;
        cmd.addr_sel = acx_pkg::AS_PC2;
      end
      acx_pkg::S_B2:     cmd.cap_b2 = 1'b1;
      acx_pkg::S_PTR_LO: cmd.addr_sel = acx_pkg::AS_ZP;
      acx_pkg::S_PTR_HI: begin
        cmd.cap_ptr_lo = 1'b1;
        cmd.addr_sel   = acx_pkg::AS_ZP1;
      end
      acx_pkg::S_PTR_W:  cmd.cap_b2 = 1'b1;
      acx_pkg::S_RD_EA:  cmd.addr_sel = acx_pkg::AS_EA;
      acx_pkg::S_ADD:    cmd.do_add = 1'b1;
      acx_pkg::S_DONE:   cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_exec_fetch: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && in_mode) |=> state == acx_pkg::S_B1)
    else $error("execute word did not start operand fetch");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result valid without load");

  a_no_add_bad: assert property (@(posedge clk) disable iff (rst)
    cmd.do_add |-> status.am != acx_pkg::AM_BAD)
    else $error("add on unknown opcode");

endmodule

// ===== rtl/acx_datapath.sv =====
// Datapath: byte memory, index registers, PC, accumulator, flags, operand
// registers, address mux, adder and result register. Uses acx_pkg; commanded by acx_ctrl.
module acx_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  acx_pkg::cmd_t         cmd,
  output acx_pkg::status_t      status,
  input  logic                  in_mode,
  input  logic [15:0]           in_mem_addr,
  input  logic [7:0]            in_mem_data,
  input  logic [7:0]            in_opcode,
  acx_cfg_if.sink               cfg,
  output logic [7:0]            acc_out,
  output logic                  carry_flag,
  output logic                  zero_flag,
  output logic                  overflow_flag,
  output logic                  negative_flag,
  output logic [15:0]           pc_out,
  output logic [2:0]            cycle_count,
  output logic                  bad_opcode
);

  logic [7:0]  mem [acx_pkg::MEM_DEPTH];
  logic [7:0]  rdata;
  logic [acx_pkg::ADDR_BITS-1:0] mem_addr;
  logic        mem_we;

  logic [7:0]  index_x, index_y;
  logic [15:0] pc;
  logic [7:0]  acc;
  logic        flag_c, flag_z, flag_v, flag_n;
  logic [7:0]  op;
  logic        is_exec;
  logic [7:0]  b1, b2, ptr_lo;

  acx_pkg::addr_mode_t am;
  logic [7:0]  zp, zp1;
  logic [15:0] ea, pc1, pc2;
  logic [7:0]  operand;
  logic [8:0]  sum;

  assign cfg.ready = 1'b1;
  assign am        = acx_pkg::decode_am(op);
  assign status.am = am;

  assign pc1 = pc + 16'd1;
  assign pc2 = pc + 16'd2;
  assign zp  = b1 + ((am == acx_pkg::AM_INDX) ? index_x : 8'd0);
  assign zp1 = zp + 8'd1;

  always_comb begin
    case (am)
      acx_pkg::AM_ZP:   ea = {8'd0, b1};
      acx_pkg::AM_ZPX:  ea = {8'd0, b1 + index_x};
      acx_pkg::AM_ABSX: ea = {b2, b1} + {8'd0, index_x};
      acx_pkg::AM_ABSY: ea = {b2, b1} + {8'd0, index_y};
      acx_pkg::AM_INDX: ea = {b2, ptr_lo};
      acx_pkg::AM_INDY: ea = {b2, ptr_lo} + {8'd0, index_y};
      default:          ea = {b2, b1};
    endcase
  end

  assign mem_we = cmd.accept && !in_mode;

  always_comb begin
    if (mem_we) begin
      mem_addr = in_mem_addr[acx_pkg::ADDR_BITS-1:0];
    end else begin
      case (cmd.addr_sel)
        acx_pkg::AS_PC1: mem_addr = pc1[acx_pkg::ADDR_BITS-1:0];
        acx_pkg::AS_PC2: mem_addr = pc2[acx_pkg::ADDR_BITS-1:0];
        acx_pkg::AS_ZP:  mem_addr = acx_pkg::ADDR_BITS'(zp);
        acx_pkg::AS_ZP1: mem_addr = acx_pkg::ADDR_BITS'(zp1);
        default:         mem_addr = ea[acx_pkg::ADDR_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= in_mem_data;
    rdata <= mem[mem_addr];
  end

  assign operand = (am == acx_pkg::AM_IMM) ? b1 : rdata;
  assign sum     = {1'b0, acc} + {1'b0, operand} + {8'd0, flag_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      index_x <= 8'd0;
      index_y <= 8'd0;
      pc      <= 16'd0;
      acc     <= 8'd0;
      flag_c  <= 1'b0;
      flag_z  <= 1'b0;
      flag_v  <= 1'b0;
      flag_n  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.index == acx_pkg::CFG_INDEX_X) index_x <= cfg.data;
      if (cfg.valid && cfg.index == acx_pkg::CFG_INDEX_Y) index_y <= cfg.data;
      if (cmd.do_add) begin
        acc    <= sum[7:0];
        flag_c <= sum[8];
        flag_z <= sum[7:0] == 8'd0;
        flag_v <= ~(acc[7] ^ operand[7]) & (acc[7] ^ sum[7]);
        flag_n <= sum[7];
        pc     <= pc + {14'd0, acx_pkg::am_len(am)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= in_opcode;
      is_exec <= in_mode;
    end
    if (cmd.cap_b1)     b1     <= rdata;
    if (cmd.cap_b2)     b2     <= rdata;
    if (cmd.cap_ptr_lo) ptr_lo <= rdata;
    if (cmd.load_out) begin
      acc_out       <= acc;
      carry_flag    <= flag_c;
      zero_flag     <= flag_z;
      overflow_flag <= flag_v;
      negative_flag <= flag_n;
      pc_out        <= pc;
      cycle_count   <= is_exec ? acx_pkg::am_cycles(am) : acx_pkg::CYC_NONE;
      bad_opcode    <= is_exec && (am == acx_pkg::AM_BAD);
    end
  end

  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.do_add)) |-> $stable(pc))
    else $error("program counter moved without an add");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.do_add)) |-> $stable(acc))
    else $error("accumulator moved without an add");

endmodule

// ===== tb/adc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the add-with-carry executor: watches the request, result and config
// channels, predicts every result word and compares it field by field.
// Depends on acx_pkg, acx_in_if, acx_out_if and acx_cfg_if.
module adc_result_checker
  import acx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  acx_in_if    req,
  acx_out_if   rsp,
  acx_cfg_if   cfg,
  output int   mismatches,
  output int   outcomes_due
);

  localparam int MEM_MASK  = MEM_DEPTH - 1;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0]  acc;
    logic        c;
    logic        z;
    logic        v;
    logic        n;
    logic [15:0] pc;
    logic [2:0]  cycles;
    logic        bad;
  } adc_word_t;

  logic [7:0]  image [0:MEM_DEPTH-1];
  logic [15:0] pc;
  logic [7:0]  acc;
  logic        flag_c, flag_z, flag_v, flag_n;
  logic [7:0]  ix, iy;
  adc_word_t   outcome_q [$];
  adc_word_t   got, want;

  function automatic int idx(logic [15:0] a);
    return int'(a) & MEM_MASK;
  endfunction

  // pointer from page zero; high byte wraps within the page
  function automatic logic [15:0] page0_ptr(logic [7:0] zp);
    return {image[idx({8'h00, zp + 8'd1})], image[idx({8'h00, zp})]};
  endfunction

  function automatic adc_word_t apply_request(logic mode, logic [15:0] addr,
                                              logic [7:0] data, logic [7:0] op);
    logic [7:0]  b1, b2, m;
    logic [15:0] ea, step;
    logic [8:0]  sum;
    logic [2:0]  cyc;
    logic        bad, imm;
    cyc  = CYC_NONE;
    bad  = 1'b0;
    imm  = 1'b0;
    ea   = '0;
    step = 16'd2;
    if (!mode) begin
      image[idx(addr)] = data;
    end else begin
      b1 = image[idx(pc + 16'd1)];
      b2 = image[idx(pc + 16'd2)];
      case (op)
        OP_ADC_IMM: begin
          imm = 1'b1;
          cyc = CYC_IMM;
        end
        OP_ADC_ZP: begin
          ea  = {8'h00, b1};
          cyc = CYC_ZP;
        end
        OP_ADC_ZPX: begin
          ea  = {8'h00, 8'(b1 + ix)};
          cyc = CYC_MID;
        end
        OP_ADC_ABS: begin
          ea   = {b2, b1};
          step = 16'd3;
          cyc  = CYC_MID;
        end
        OP_ADC_ABSX: begin
          ea   = {b2, b1} + {8'h00, ix};
          step = 16'd3;
          cyc  = CYC_MID;
        end
        OP_ADC_ABSY: begin
          ea   = {b2, b1} + {8'h00, iy};
          step = 16'd3;
          cyc  = CYC_MID;
        end
        OP_ADC_INDX: begin
          ea  = page0_ptr(8'(b1 + ix));
          cyc = CYC_IND;
        end
        OP_ADC_INDY: begin
          ea  = page0_ptr(b1) + {8'h00, iy};
          cyc = CYC_IND;
        end
        default: bad = 1'b1;
      endcase
      if (!bad) begin
        m      = imm ? b1 : image[idx(ea)];
        sum    = {1'b0, acc} + {1'b0, m} + {8'h00, flag_c};
        flag_v = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
        acc    = sum[7:0];
        flag_c = sum[8];
        flag_z = (sum[7:0] == 8'h00);
        flag_n = sum[7];
        pc     = pc + step;
      end
    end
    return '{acc: acc, c: flag_c, z: flag_z, v: flag_v, n: flag_n,
             pc: pc, cycles: cyc, bad: bad};
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s got %0h expected %0h", $time, what, got_v, want_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pc     = '0;
      acc    = '0;
      flag_c = 1'b0;
      flag_z = 1'b0;
      flag_v = 1'b0;
      flag_n = 1'b0;
      ix     = '0;
      iy     = '0;
      outcome_q.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_INDEX_X) ix = cfg.data;
        else if (cfg.index == CFG_INDEX_Y) iy = cfg.data;
      end
      if (req.valid && req.ready)
        outcome_q.push_back(apply_request(req.mode, req.mem_addr, req.mem_data, req.opcode));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.acc_out, rsp.carry_flag, rsp.zero_flag, rsp.overflow_flag,
               rsp.negative_flag, rsp.pc_out, rsp.cycle_count, rsp.bad_opcode};
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with none due, acc_out", int'(got.acc), 0);
        end else begin
          want = outcome_q.pop_front();
          if (got.acc != want.acc)
            report_mismatch("acc_out", int'(got.acc), int'(want.acc));
          if (got.c != want.c)
            report_mismatch("carry_flag", int'(got.c), int'(want.c));
          if (got.z != want.z)
            report_mismatch("zero_flag", int'(got.z), int'(want.z));
          if (got.v != want.v)
            report_mismatch("overflow_flag", int'(got.v), int'(want.v));
          if (got.n != want.n)
            report_mismatch("negative_flag", int'(got.n), int'(want.n));
          if (got.pc != want.pc)
            report_mismatch("pc_out", int'(got.pc), int'(want.pc));
          if (got.cycles != want.cycles)
            report_mismatch("cycle_count", int'(got.cycles), int'(want.cycles));
          if (got.bad != want.bad)
            report_mismatch("bad_opcode", int'(got.bad), int'(want.bad));
        end
      end
    end
    outcomes_due = outcome_q.size();
  end

endmodule

// ===== tb/cpu_add_with_carry_executor_core_test.sv =====
`timescale 1ns / 100ps
// Top of the add-with-carry executor testbench: clock, reset, request and config stimulus,
// result-side stalls and the verdict. Checking is done by adc_result_checker.
// Depends on acx_pkg, the three channel interfaces, the core and adc_result_checker.
module cpu_add_with_carry_executor_core_test;
  import acx_pkg::*;

  localparam int MEM_MASK        = MEM_DEPTH - 1;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASE_WORDS     = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [7:0] BAD_OP_LOW  = 8'h00;
  localparam logic [7:0] BAD_OP_HIGH = 8'hFF;
  localparam logic [7:0] ADC_OPS [0:7] = '{OP_ADC_IMM, OP_ADC_ZP, OP_ADC_ZPX, OP_ADC_ABS,
                                           OP_ADC_ABSX, OP_ADC_ABSY, OP_ADC_INDX,
                                           OP_ADC_INDY};

  logic clk = 1'b0;
  logic rst;

  acx_in_if  req_if();
  acx_out_if rsp_if();
  acx_cfg_if cfg_if();

  int mismatches;
  int outcomes_due;
  int cycle_no = 0;
  int words_sent = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  // stimulus-side image of memory, used only to keep every read on written bytes
  logic [7:0]  plan_mem [0:MEM_DEPTH-1];
  bit          plan_set [0:MEM_DEPTH-1];
  logic [15:0] plan_pc = '0;
  logic [7:0]  plan_x = '0;
  logic [7:0]  plan_y = '0;

  cpu_add_with_carry_executor_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  adc_result_checker result_watch (
    .clk          (clk),
    .rst          (rst),
    .req          (req_if),
    .rsp          (rsp_if),
    .cfg          (cfg_if),
    .mismatches   (mismatches),
    .outcomes_due (outcomes_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idx(logic [15:0] a);
    return int'(a) & MEM_MASK;
  endfunction

  function automatic int code_bytes(logic [7:0] op);
    case (op)
      OP_ADC_ABS, OP_ADC_ABSX, OP_ADC_ABSY: return 3;
      OP_ADC_IMM, OP_ADC_ZP, OP_ADC_ZPX, OP_ADC_INDX, OP_ADC_INDY: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Walks the fetch chain of op; returns 1 with spot at the first byte not yet written,
  // else 0 with spot at the operand address when the mode has one.
  function automatic bit find_gap(input logic [7:0] op, output logic [15:0] spot,
                                  output bit has_ea);
    logic [7:0]  b1, b2, zp;
    logic [15:0] ptr;
    has_ea = 1'b0;
    spot = plan_pc + 16'd1;
    if (!plan_set[idx(spot)]) return 1'b1;
    spot = plan_pc + 16'd2;
    if (!plan_set[idx(spot)]) return 1'b1;
    b1 = plan_mem[idx(plan_pc + 16'd1)];
    b2 = plan_mem[idx(plan_pc + 16'd2)];
    case (op)
      OP_ADC_ZP:   spot = {8'h00, b1};
      OP_ADC_ZPX:  spot = {8'h00, 8'(b1 + plan_x)};
      OP_ADC_ABS:  spot = {b2, b1};
      OP_ADC_ABSX: spot = {b2, b1} + {8'h00, plan_x};
      OP_ADC_ABSY: spot = {b2, b1} + {8'h00, plan_y};
      OP_ADC_INDX, OP_ADC_INDY: begin
        zp = (op == OP_ADC_INDX) ? 8'(b1 + plan_x) : b1;
        spot = {8'h00, zp};
        if (!plan_set[idx(spot)]) return 1'b1;
        spot = {8'h00, zp + 8'd1};
        if (!plan_set[idx(spot)]) return 1'b1;
        ptr = {plan_mem[idx({8'h00, zp + 8'd1})], plan_mem[idx({8'h00, zp})]};
        spot = (op == OP_ADC_INDY) ? ptr + {8'h00, plan_y} : ptr;
      end
      default: return 1'b0;
    endcase
    has_ea = 1'b1;
    return !plan_set[idx(spot)];
  endfunction

  task automatic send_word(logic mode, logic [15:0] addr, logic [7:0] data, logic [7:0] op);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.mem_addr <= addr;
    req_if.mem_data <= data;
    req_if.opcode   <= op;
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
    words_sent++;
  endtask

  task automatic put_byte(logic [15:0] addr, logic [7:0] value);
    send_word(1'b0, addr, value, 8'($urandom));
    plan_mem[idx(addr)] = value;
    plan_set[idx(addr)] = 1'b1;
  endtask

  task automatic fill_operands(logic [7:0] op);
    logic [15:0] spot;
    bit          has_ea;
    while (find_gap(op, spot, has_ea)) put_byte(spot, rand_byte());
  endtask

  task automatic exec(logic [7:0] op);
    fill_operands(op);
    send_word(1'b1, 16'($urandom), 8'($urandom), op);
    plan_pc = plan_pc + 16'(code_bytes(op));
  endtask

  // fresh operand bytes most of the time, reuse of stale memory otherwise
  task automatic random_exec(logic [7:0] op);
    logic [15:0] spot;
    bit          has_ea;
    if ($urandom_range(0, 3) != 0) put_byte(plan_pc + 16'd1, rand_byte());
    if ($urandom_range(0, 1) != 0) put_byte(plan_pc + 16'd2, rand_byte());
    fill_operands(op);
    if (!find_gap(op, spot, has_ea) && has_ea && $urandom_range(0, 1) != 0)
      put_byte(spot, rand_byte());
    exec(op);
  endtask

  task automatic drain();
    @(negedge clk) req_if.valid <= 1'b0;
    burst_left = 0;
    while (outcomes_due != 0) @(posedge clk);
  endtask

  task automatic set_index(logic [CFG_IDX_BITS-1:0] which, logic [7:0] value);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= which;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk) cfg_if.valid <= 1'b0;
    if (which == CFG_INDEX_X) plan_x = value;
    else plan_y = value;
  endtask

  // squeeze starts the long result-side hold-off once the index writes are done
  task automatic run_phase(logic [7:0] x, logic [7:0] y, int words, bit squeeze);
    int          stop;
    int          pick;
    logic [7:0]  op;
    set_index(CFG_INDEX_X, x);
    set_index(CFG_INDEX_Y, y);
    if (squeeze) hold_off_req = 1'b1;
    stop = words_sent + words;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        put_byte(16'($urandom), rand_byte());
      end else if (pick < 3) begin
        do op = 8'($urandom); while (code_bytes(op) != 0);
        exec(op);
      end else begin
        random_exec(ADC_OPS[$urandom_range(0, 7)]);
      end
    end
  endtask

  initial begin : result_side
    int style;
    int span;
    rsp_if.ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk) rsp_if.ready <= 1'b0;
      end else begin
        style = $urandom_range(0, 2);
        span  = $urandom_range(10, 80);
        repeat (span) begin
          @(negedge clk);
          case (style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin : request_side
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.mode     = 1'b0;
    req_if.mem_addr = '0;
    req_if.mem_data = '0;
    req_if.opcode   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_INDEX_X;
    cfg_if.data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    set_index(CFG_INDEX_X, 8'hFF);
    set_index(CFG_INDEX_Y, 8'h01);
    exec(BAD_OP_LOW);
    put_byte(16'h0001, 8'h00);
    exec(OP_ADC_IMM);                  // zero result
    put_byte(16'h0003, 8'hFF);
    exec(OP_ADC_IMM);                  // negative
    put_byte(16'h0005, 8'h00);
    put_byte(16'h0000, 8'h01);
    exec(OP_ADC_ZP);                   // carry out, zero
    put_byte(16'h0007, 8'h80);
    put_byte(16'h007F, 8'h7F);
    exec(OP_ADC_ZPX);                  // page-zero wrap, carry in, overflow
    put_byte(16'h0009, 8'hFF);
    put_byte(16'h000A, 8'hFF);
    put_byte(16'hFFFF, 8'h80);
    exec(OP_ADC_ABS);                  // top address, overflow with carry out
    put_byte(16'h000C, 8'hF0);
    put_byte(16'h000D, 8'hFF);
    put_byte(16'h00EF, 8'hFF);
    exec(OP_ADC_ABSX);                 // 16-bit wrap of indexed address
    put_byte(16'h000F, 8'h34);
    put_byte(16'h0010, 8'h12);
    exec(OP_ADC_ABSY);
    put_byte(16'h0012, 8'h00);
    put_byte(16'h00FF, 8'h00);
    put_byte(16'h0100, 8'h7F);
    exec(OP_ADC_INDX);                 // pointer high byte wraps to page zero
    put_byte(16'h0014, 8'hFF);
    put_byte(16'h00FF, 8'hFF);
    put_byte(16'h0000, 8'hFF);
    exec(OP_ADC_INDY);                 // pointer plus Y wraps to zero
    exec(BAD_OP_HIGH);

    run_phase(8'h00, 8'h00, PHASE_WORDS, 1'b0);
    run_phase(8'hFF, 8'hFF, PHASE_WORDS, 1'b1);
    run_phase(8'h00, 8'hFF, PHASE_WORDS, 1'b0);
    run_phase(8'hFF, 8'h00, PHASE_WORDS, 1'b0);
    run_phase(8'($urandom), 8'($urandom), PHASE_WORDS, 1'b0);
    run_phase(8'($urandom), 8'($urandom), PHASE_WORDS, 1'b0);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
